// ===== rtl/core/rmts_pkg.sv =====
// ----------------------------------------------------------------------------
// rmts_pkg: shared constants for the range minimum threshold sweep block
// Widths of the slot table and of the beat fields.
// ----------------------------------------------------------------------------
package rmts_pkg;
    localparam int NUM_SLOTS  = 1024;
    localparam int VALUE_BITS = 32;
    localparam int IDX_BITS   = $clog2(NUM_SLOTS);
    localparam int POS_BITS   = IDX_BITS + 1;
    localparam int CNT_BITS   = 11;
    localparam logic [VALUE_BITS-1:0] EMPTY_MARK = '1;
    localparam logic [CNT_BITS-1:0]   COUNT_MAX  = '1;
    localparam logic OP_SET   = 1'b0;
    localparam logic OP_SWEEP = 1'b1;
    localparam int IN_BITS = 1 + 10 + 32 + 11 + 11 + 32;
    localparam int IN_BYTES_BITS = ((IN_BITS + 7) / 8) * 8;
endpackage

// ===== rtl/core/range_min_threshold_sweep.sv =====
// ----------------------------------------------------------------------------
// range_min_threshold_sweep: slot table with threshold range sweep
// A set beat writes one slot; a sweep beat empties slots at or below a
// threshold in a range and returns the number emptied.
// ----------------------------------------------------------------------------
// Timing: a set is written at its accepting edge, gives no result, and the
// next beat can enter in the next cycle. A sweep reads its clamped range
// through the table's read port at one slot per cycle, then passes through
// a drain and a done step before the count is valid and the next beat can
// enter; a count still stalled on the output holds the sweep in its last step.
// After reset a clearing pass writes the empty mark to every slot while
// s_axis_tready stays low.
// The result register lets the next beat enter while a count is pending.
module range_min_threshold_sweep
    import rmts_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // tdata from bit 0: opcode(1), position(10), new_value(32),
    // range_start(11), range_end(11), threshold(32), zero fill
    input  logic [IN_BYTES_BITS-1:0] s_axis_tdata,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // tdata from bit 0: removed_count(11), zero fill
    output logic [15:0]              m_axis_tdata
);
    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SWEEP = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [VALUE_BITS-1:0] mem [NUM_SLOTS];
    logic [2:0]            state_reg, state_next;
    logic [POS_BITS-1:0]   addr_reg, addr_next;   // next slot to read
    logic [POS_BITS-1:0]   end_reg, end_next;
    logic [VALUE_BITS-1:0] thr_reg, thr_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic                  rd_pend_reg, rd_pend_next;
    logic [IDX_BITS-1:0]   rd_idx_reg, rd_idx_next;
    logic [VALUE_BITS-1:0] rd_data_reg;
    logic                  ovalid_reg, ovalid_next;
    logic [CNT_BITS-1:0]   odata_reg, odata_next;
    logic                  we;
    logic [IDX_BITS-1:0]   waddr;
    logic [VALUE_BITS-1:0] wdata;
    logic                  re;
    logic                  hit;
    logic                  in_fire;

    logic                  f_op;
    logic [9:0]            f_pos;
    logic [31:0]           f_val;
    logic [10:0]           f_start, f_end;
    logic [31:0]           f_thr;
    logic [POS_BITS-1:0]   clamp_end;

    assign f_op    = s_axis_tdata[0];
    assign f_pos   = s_axis_tdata[10:1];
    assign f_val   = s_axis_tdata[42:11];
    assign f_start = s_axis_tdata[53:43];
    assign f_end   = s_axis_tdata[64:54];
    assign f_thr   = s_axis_tdata[96:65];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign clamp_end = (f_end > 11'(NUM_SLOTS)) ? POS_BITS'(NUM_SLOTS) : POS_BITS'(f_end);
    assign hit = rd_pend_reg && (rd_data_reg != EMPTY_MARK) && (rd_data_reg <= thr_reg);

    always_comb begin
        state_next   = state_reg;
        addr_next    = addr_reg;
        end_next     = end_reg;
        thr_next     = thr_reg;
        cnt_next     = cnt_reg;
        rd_pend_next = 1'b0;
        rd_idx_next  = rd_idx_reg;
        ovalid_next  = ovalid_reg && !m_axis_tready;
        odata_next   = odata_reg;
        we    = 1'b0;
        waddr = rd_idx_reg;
        wdata = EMPTY_MARK;
        re    = 1'b0;
        // A read issued last cycle returns now; empty it if it qualifies.
        // Reads advance by one slot, so no write ever targets a later read.
        if (hit) begin
            we = 1'b1;
            if (cnt_reg != COUNT_MAX) begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
        case (state_reg)
            ST_CLEAR: begin
                we    = 1'b1;
                waddr = addr_reg[IDX_BITS-1:0];
                addr_next = addr_reg + 1'b1;
                if (addr_reg == POS_BITS'(NUM_SLOTS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_fire) begin
                    if (f_op == OP_SET) begin
                        if ({1'b0, f_pos} < POS_BITS'(NUM_SLOTS)) begin
                            we    = 1'b1;
                            waddr = f_pos[IDX_BITS-1:0];
                            wdata = f_val[VALUE_BITS-1:0];
                        end
                    end else begin
                        addr_next  = POS_BITS'(f_start);
                        end_next   = clamp_end;
                        thr_next   = f_thr[VALUE_BITS-1:0];
                        cnt_next   = '0;
                        state_next = ST_SWEEP;
                    end
                end
            end
            ST_SWEEP: begin
                if (addr_reg < end_reg) begin
                    re           = 1'b1;
                    rd_pend_next = 1'b1;
                    rd_idx_next  = addr_reg[IDX_BITS-1:0];
                    addr_next    = addr_reg + 1'b1;
                end else begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!ovalid_next) begin
                    ovalid_next = 1'b1;
                    odata_next  = cnt_reg;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rd_data_reg <= mem[addr_reg[IDX_BITS-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            addr_reg    <= '0;
            rd_pend_reg <= 1'b0;
            ovalid_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            addr_reg    <= addr_next;
            rd_pend_reg <= rd_pend_next;
            ovalid_reg  <= ovalid_next;
        end
        end_reg    <= end_next;
        thr_reg    <= thr_next;
        cnt_reg    <= cnt_next;
        rd_idx_reg <= rd_idx_next;
        odata_reg  <= odata_next;
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {5'b0, odata_reg};

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_axis_tready)
        else $error("input accepted while busy");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result dropped while stalled");
    a_read_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_pend_reg |-> ($past(state_reg) == ST_SWEEP))
        else $error("read outside sweep");
endmodule
